// ----- hdl/crcfr_pkg.sv -----
// Shared types, constants and the CRC byte update for the CRC-16 frame receiver.
package crcfr_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  TERM_BYTE = 8'h0A;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_CRC_BAD = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;
    localparam logic [1:0] ST_ABORT   = 2'd3;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
        logic       is_term;
    } t_q_entry;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/crcfr_if.sv -----
// Valid/ready channel interfaces for input words and frame reports.
interface crcfr_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface crcfr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [8:0]  frame_length;
    logic [7:0]  frame_address;
    logic [15:0] frame_crc;
    logic [15:0] calc_crc;

    modport source (output valid, output status, output frame_length, output frame_address,
                    output frame_crc, output calc_crc, input ready);
    modport sink   (input valid, input status, input frame_length, input frame_address,
                    input frame_crc, input calc_crc, output ready);
endinterface

// ----- hdl/crcfr_front.sv -----
// Front end: accepts input words, tags terminators, buffers them in a short queue.
module crcfr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    crcfr_in_if.sink            i_in,
    input  logic                i_pop,
    output logic                o_q_valid,
    output crcfr_pkg::t_q_entry o_q_entry
);
    import crcfr_pkg::*;

    t_q_entry       r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;
    logic           push;
    logic           pop;
    t_q_entry       in_entry;

    assign i_in.ready = (r_count != (QAW+1)'(QDEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && o_q_valid;

    assign in_entry.operation = i_in.operation;
    assign in_entry.rx_byte   = i_in.rx_byte;
    assign in_entry.is_term   = (i_in.operation == OP_BYTE) && (i_in.rx_byte == TERM_BYTE);

    assign o_q_valid = (r_count != '0);
    assign o_q_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/crcfr_back.sv -----
// Back end: frame tracking, CRC update and the registered frame report.
module crcfr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [8:0]          i_limit,
    input  logic                i_q_valid,
    input  crcfr_pkg::t_q_entry i_q_entry,
    output logic                o_pop,
    crcfr_out_if.source         o_out
);
    import crcfr_pkg::*;

    localparam logic [1:0] PH_BODY = 2'd0;
    localparam logic [1:0] PH_CRC1 = 2'd1;
    localparam logic [1:0] PH_CRC2 = 2'd2;

    logic [15:0] r_crc, n_crc;
    logic [15:0] r_delay, n_delay;
    logic [8:0]  r_count, n_count;
    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_addr, n_addr;

    logic        r_out_valid;
    logic [1:0]  r_status, n_status;
    logic [8:0]  r_len, n_len;
    logic [7:0]  r_out_addr, n_out_addr;
    logic [15:0] r_rx_crc, n_rx_crc;
    logic [15:0] r_cmp_crc, n_cmp_crc;

    logic        take;
    logic        emit;
    logic        finish;
    logic [15:0] upd_crc;
    logic [15:0] upd_delay;
    logic [7:0]  upd_addr;
    logic [8:0]  upd_count;

    assign take  = i_q_valid && (!r_out_valid || o_out.ready);
    assign o_pop = take;

    // state after absorbing one byte, before the end-of-frame decision
    always_comb begin
        upd_crc   = (r_count >= 9'd2) ? crc_feed(r_crc, r_delay[7:0]) : r_crc;
        upd_delay = {i_q_entry.rx_byte, r_delay[15:8]};
        upd_addr  = (r_count == '0) ? i_q_entry.rx_byte : r_addr;
        upd_count = r_count + 9'd1;
    end

    always_comb begin
        n_crc      = r_crc;
        n_delay    = r_delay;
        n_count    = r_count;
        n_phase    = r_phase;
        n_addr     = r_addr;
        n_status   = r_status;
        n_len      = r_len;
        n_out_addr = r_out_addr;
        n_rx_crc   = r_rx_crc;
        n_cmp_crc  = r_cmp_crc;
        emit       = 1'b0;
        finish     = 1'b0;

        if (take) begin
            if (i_q_entry.operation == OP_TIMEOUT) begin
                if (r_count != '0) begin
                    emit       = 1'b1;
                    n_status   = ST_ABORT;
                    n_len      = r_count;
                    n_out_addr = r_addr;
                    n_rx_crc   = '0;
                    n_cmp_crc  = '0;
                    n_crc      = CRC_INIT;
                    n_delay    = '0;
                    n_count    = '0;
                    n_phase    = PH_BODY;
                    n_addr     = '0;
                end
            end else begin
                n_crc   = upd_crc;
                n_delay = upd_delay;
                n_addr  = upd_addr;
                n_count = upd_count;
                unique case (r_phase)
                    PH_CRC1: begin
                        n_phase = PH_CRC2;
                    end
                    PH_CRC2: begin
                        finish = 1'b1;
                    end
                    default: begin
                        if (i_q_entry.is_term) begin
                            n_phase = PH_CRC1;
                        end else if (upd_count >= i_limit - 9'd1) begin
                            finish = 1'b1;
                        end
                    end
                endcase
                if (finish) begin
                    emit       = 1'b1;
                    n_len      = upd_count;
                    n_out_addr = upd_addr;
                    if (upd_count < 9'd4) begin
                        n_status  = ST_SHORT;
                        n_rx_crc  = '0;
                        n_cmp_crc = '0;
                    end else begin
                        n_status  = (upd_delay == upd_crc) ? ST_VALID : ST_CRC_BAD;
                        n_rx_crc  = upd_delay;
                        n_cmp_crc = upd_crc;
                    end
                    n_crc   = CRC_INIT;
                    n_delay = '0;
                    n_count = '0;
                    n_phase = PH_BODY;
                    n_addr  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_delay     <= '0;
            r_count     <= '0;
            r_phase     <= PH_BODY;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_crc   <= n_crc;
            r_delay <= n_delay;
            r_count <= n_count;
            r_phase <= n_phase;
            r_addr  <= n_addr;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_len      <= n_len;
        r_out_addr <= n_out_addr;
        r_rx_crc   <= n_rx_crc;
        r_cmp_crc  <= n_cmp_crc;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.frame_length  = r_len;
    assign o_out.frame_address = r_out_addr;
    assign o_out.frame_crc     = r_rx_crc;
    assign o_out.calc_crc      = r_cmp_crc;

endmodule

// ----- hdl/crc16_frame_receiver.sv -----
// Top level: frame size register, front queue and back-end frame engine.
//
//  channel   dir  fields                                          handshake
//  i_in      in   operation, rx_byte                              valid/ready
//  o_out     out  status, frame_length, frame_address,            valid/ready
//                 frame_crc, calc_crc
//  i_cfg_*   in   max_frame_len                                   write enable
//
// One word per cycle unless stalled; a word is stored in the 4-entry queue,
// then reaches the report register once the back end takes it.
// Back end: one word per cycle unless stalled (byte CRC update, compare).
// Reset is synchronous: queue empty, frame state cleared, size register 256.
// A stalled report holds the back end; the queue keeps taking words until full.
module crc16_frame_receiver #(
    parameter int MAX_FRAME = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_wdata,
    crcfr_in_if.sink   i_in,
    crcfr_out_if.source o_out
);
    import crcfr_pkg::*;

    localparam int          LIM_TOP_I = (MAX_FRAME < 256) ? MAX_FRAME : 256;
    localparam logic [8:0]  LIM_TOP   = 9'(LIM_TOP_I);

    logic [8:0] r_max_len;
    logic [8:0] limit;
    logic       q_valid;
    logic       pop;
    t_q_entry   q_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 9'd256;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    // effective frame size limit clamped to the range 2..LIM_TOP
    always_comb begin
        if (r_max_len > LIM_TOP) begin
            limit = LIM_TOP;
        end else if (r_max_len < 9'd2) begin
            limit = 9'd2;
        end else begin
            limit = r_max_len;
        end
    end

    crcfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_pop     (pop),
        .o_q_valid (q_valid),
        .o_q_entry (q_entry)
    );

    crcfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_limit   (limit),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ----- tb/frame_checker.sv -----
`timescale 1ns / 1ps
// Frame report checker: watches both channels, predicts each report and compares it.
module frame_checker #(
    parameter int MAX_FRAME = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_wdata,
    crcfr_in_if        i_in_mon,
    crcfr_out_if       i_out_mon,
    output int         o_fail_count,
    output int         o_reports_pending,
    output int         o_status_seen [4]
);
    import crcfr_pkg::*;

    localparam logic [1:0] PH_BODY   = 2'd0;
    localparam logic [1:0] PH_CRC_LO = 2'd1;
    localparam logic [1:0] PH_CRC_HI = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  length;
        logic [7:0]  address;
        logic [15:0] rx_crc;
        logic [15:0] calc_crc;
    } t_frame_report;

    t_frame_report reports_due [$];

    logic [15:0] crc_acc;
    logic [15:0] tail_pair;   // [7:0] is the older of the last two bytes
    logic [8:0]  bytes_in;
    logic [1:0]  frame_phase;
    logic [7:0]  addr_byte;
    logic [8:0]  size_reg;
    int          report_idx;

    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                      input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
        return r;
    endfunction

    function automatic void clear_frame();
        crc_acc     = CRC_INIT;
        tail_pair   = '0;
        bytes_in    = '0;
        frame_phase = PH_BODY;
        addr_byte   = '0;
    endfunction

    function automatic int frame_size_limit();
        int lim;
        int top;
        lim = size_reg;
        top = (MAX_FRAME < 256) ? MAX_FRAME : 256;
        if (lim > top) lim = top;
        if (lim < 2) lim = 2;
        return lim;
    endfunction

    // Advances the receiver by one word; returns 1 when a frame report falls out.
    function automatic bit predict_frame_report(input logic op, input logic [7:0] b,
                                                output t_frame_report rep);
        rep = '0;
        if (op == OP_TIMEOUT) begin
            if (bytes_in == 0) return 1'b0;
            rep.status  = ST_ABORT;
            rep.length  = bytes_in;
            rep.address = addr_byte;
            clear_frame();
            return 1'b1;
        end

        // CRC trails the input by two bytes so the CRC bytes never enter it
        if (bytes_in >= 2) crc_acc = crc16_modbus_byte(crc_acc, tail_pair[7:0]);
        tail_pair = {b, tail_pair[15:8]};
        if (bytes_in == 0) addr_byte = b;
        bytes_in = bytes_in + 9'd1;

        if (frame_phase == PH_CRC_LO) begin
            frame_phase = PH_CRC_HI;
            return 1'b0;
        end
        if (frame_phase != PH_CRC_HI) begin
            if (b == TERM_BYTE) begin
                frame_phase = PH_CRC_LO;
                return 1'b0;
            end
            if (int'(bytes_in) < frame_size_limit() - 1) return 1'b0;
        end

        rep.length  = bytes_in;
        rep.address = addr_byte;
        if (bytes_in < 4) begin
            rep.status = ST_SHORT;
        end else begin
            rep.status   = (tail_pair == crc_acc) ? ST_VALID : ST_CRC_BAD;
            rep.rx_crc   = tail_pair;
            rep.calc_crc = crc_acc;
        end
        clear_frame();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        o_fail_count++;
        $display("%0t report %0d: %s expected 0x%0h, got 0x%0h",
                 $time, report_idx, what, want_v, got_v);
    endtask

    initial begin
        o_fail_count      = 0;
        o_reports_pending = 0;
        report_idx        = 0;
        size_reg          = 9'd256;
        for (int i = 0; i < 4; i++) o_status_seen[i] = 0;
        clear_frame();
    end

    always @(posedge i_clk) begin
        t_frame_report want;
        t_frame_report got;
        if (!i_rst_n) begin
            size_reg = 9'd256;
            clear_frame();
            reports_due.delete();
        end else begin
            if (i_cfg_we) size_reg = i_cfg_wdata;

            if (i_in_mon.valid && i_in_mon.ready) begin
                if (predict_frame_report(i_in_mon.operation, i_in_mon.rx_byte, want))
                    reports_due.push_back(want);
            end

            if (i_out_mon.valid && i_out_mon.ready) begin
                got.status   = i_out_mon.status;
                got.length   = i_out_mon.frame_length;
                got.address  = i_out_mon.frame_address;
                got.rx_crc   = i_out_mon.frame_crc;
                got.calc_crc = i_out_mon.calc_crc;
                o_status_seen[got.status]++;
                if (reports_due.size() == 0) begin
                    report_mismatch("report with none pending, status", 0, got.status);
                end else begin
                    want = reports_due.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", want.status, got.status);
                    if (got.length !== want.length)
                        report_mismatch("frame_length", want.length, got.length);
                    if (got.address !== want.address)
                        report_mismatch("frame_address", want.address, got.address);
                    if (got.rx_crc !== want.rx_crc)
                        report_mismatch("frame_crc", want.rx_crc, got.rx_crc);
                    if (got.calc_crc !== want.calc_crc)
                        report_mismatch("calc_crc", want.calc_crc, got.calc_crc);
                end
                report_idx++;
            end
        end
        o_reports_pending = reports_due.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, word and frame stimulus, and the verdict.
module testbench;
    import crcfr_pkg::*;

    localparam int MAX_FRAME    = 256;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_WORDS  = 30;
    localparam int RUN_LIMIT_NS = 10_000_000;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [8:0] cfg_wdata;

    crcfr_in_if  in_ch ();
    crcfr_out_if out_ch ();

    int fail_count;
    int reports_pending;
    int status_seen [4];

    int       words_sent;
    int       settings_used;
    int       size_setting;
    bit       src_gaps_on;
    bit       snk_stalls_on;
    bit       long_hold_req;
    logic [8:0] size_plan [12] = '{9'd256, 9'd0, 9'd17, 9'd1, 9'd300, 9'd8,
                                   9'd511, 9'd64, 9'd255, 9'd2, 9'd6, 9'd5};

    crc16_frame_receiver #(.MAX_FRAME(MAX_FRAME)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    frame_checker #(.MAX_FRAME(MAX_FRAME)) frame_mon (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_mon          (in_ch),
        .i_out_mon         (out_ch),
        .o_fail_count      (fail_count),
        .o_reports_pending (reports_pending),
        .o_status_seen     (status_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] non_term_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == TERM_BYTE);
        return b;
    endfunction

    function automatic int eff_size();
        int lim;
        lim = size_setting;
        if (lim > ((MAX_FRAME < 256) ? MAX_FRAME : 256)) lim = (MAX_FRAME < 256) ? MAX_FRAME : 256;
        if (lim < 2) lim = 2;
        return lim;
    endfunction

    task automatic send_word(input logic op, input logic [7:0] b);
        int gap;
        gap = (src_gaps_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.rx_byte   <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
    endtask

    // Stop offering words and let every pending report come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (reports_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [8:0] v);
        cfg_we       <= 1'b1;
        cfg_wdata    <= v;
        @(posedge i_clk);
        cfg_we       <= 1'b0;
        size_setting = v;
        settings_used++;
    endtask

    task automatic send_frame(input logic [7:0] addr, input int dlen, input bit bad_crc);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = CRC_INIT;
        send_word(OP_BYTE, addr);
        crc = crc_feed(crc, addr);
        for (int i = 0; i < dlen; i++) begin
            b = non_term_byte();
            send_word(OP_BYTE, b);
            crc = crc_feed(crc, b);
        end
        send_word(OP_BYTE, TERM_BYTE);
        crc = crc_feed(crc, TERM_BYTE);
        if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        send_word(OP_BYTE, crc[7:0]);
        send_word(OP_BYTE, crc[15:8]);
    endtask

    task automatic send_random_sequence();
        int pick;
        int r;
        int lim;
        int dmax;
        int dlen;
        logic [7:0] addr;
        pick = $urandom_range(0, 99);
        lim  = eff_size();
        dmax = (lim > 3) ? lim - 3 : 0;
        if (pick < 65) begin
            r = $urandom_range(0, 99);
            if (r < 80) dlen = $urandom_range(0, (dmax < 10) ? dmax : 10);
            else if (r < 95) dlen = $urandom_range(0, (dmax < 40) ? dmax : 40);
            else dlen = $urandom_range(0, dmax);
            // an address equal to the terminator closes the body at once
            addr = ($urandom_range(0, 19) == 0) ? TERM_BYTE : non_term_byte();
            send_frame(addr, dlen, $urandom_range(0, 9) == 0);
        end else if (pick < 72 && (lim <= 64 || $urandom_range(0, 7) == 0)) begin
            // no terminator: the frame ends at the size limit
            repeat (lim - 1) send_word(OP_BYTE, non_term_byte());
        end else if (pick < 84) begin
            // frame cut by a timeout, in the body or while CRC bytes are due
            repeat ($urandom_range(1, 12)) send_word(OP_BYTE, non_term_byte());
            if ($urandom_range(0, 1)) begin
                send_word(OP_BYTE, TERM_BYTE);
                if ($urandom_range(0, 1)) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
            end
            send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
        end else if (pick < 94) begin
            repeat ($urandom_range(1, 8))
                send_word(($urandom_range(0, 3) == 0) ? OP_TIMEOUT : OP_BYTE,
                          8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) != 0) send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
        end else begin
            send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin : report_sink
        int hold_left;
        int stall_left;
        logic rdy_next;
        hold_left  = 0;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rdy_next = 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
                rdy_next      = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy_next = 1'b0;
            end else if (snk_stalls_on && $urandom_range(0, 99) < 25) begin
                stall_left = idle_len() - 1;
                rdy_next   = 1'b0;
            end else begin
                rdy_next = 1'b1;
            end
            out_ch.ready <= rdy_next;
        end
    end

    initial begin : stimulus
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= 9'd0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_BYTE;
        in_ch.rx_byte   <= 8'h00;
        words_sent      = 0;
        settings_used   = 1;
        size_setting    = 256;
        src_gaps_on     = 1'b1;
        snk_stalls_on   = 1'b1;
        long_hold_req   = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // timeout with no frame open: no report
        send_word(OP_TIMEOUT, 8'h00);
        // terminator as first byte: three-byte short frame
        send_word(OP_BYTE, TERM_BYTE);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h00);
        send_frame(8'hFF, 0, 1'b0);
        send_frame(8'h00, 3, 1'b1);
        // timeout inside the body
        send_word(OP_BYTE, 8'h55);
        send_word(OP_BYTE, 8'hA5);
        send_word(OP_TIMEOUT, 8'hFF);
        // timeout while the CRC bytes are due
        send_word(OP_BYTE, 8'h33);
        send_word(OP_BYTE, TERM_BYTE);
        send_word(OP_BYTE, 8'h12);
        send_word(OP_TIMEOUT, 8'h00);

        wait_drained();
        set_size(9'd5);
        repeat (4) send_word(OP_BYTE, non_term_byte());
        // terminator lands on the last slot; CRC bytes still taken
        send_frame(8'h01, 2, 1'b0);

        // back-to-back frames against a long receiver hold-off
        wait_drained();
        src_gaps_on   = 1'b0;
        snk_stalls_on = 1'b0;
        long_hold_req = 1'b1;
        repeat (30) send_frame(non_term_byte(), 0, 1'b0);

        for (int p = 0; p < $size(size_plan); p++) begin
            int phase_end;
            wait_drained();
            if (p == $size(size_plan) - 1) set_size(9'($urandom_range(5, 256)));
            else set_size(size_plan[p]);
            src_gaps_on   = (p % 3) != 1;
            snk_stalls_on = (p % 4) != 2;
            // longest well-formed frame the current size allows
            send_frame(non_term_byte(), (eff_size() > 3) ? eff_size() - 3 : 0, 1'b0);
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) send_random_sequence();
        end

        wait_drained();
        $display("Sent %0d input words under %0d frame-size settings.",
                 words_sent, settings_used);
        $display("Reports: %0d good, %0d CRC mismatch, %0d short, %0d timeout abort.",
                 status_seen[ST_VALID], status_seen[ST_CRC_BAD],
                 status_seen[ST_SHORT], status_seen[ST_ABORT]);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("Run limit hit, %0d reports still pending", reports_pending);
        $display("Test completed with failures");
        $finish;
    end

endmodule
